FILE: src/clpwm_pkg.sv
// Shared types and constants for the charlieplex LED PWM scanner.
package clpwm_pkg;

   // Default matrix geometry and brightness depth
   localparam int DEF_COLUMNS = 6;
   localparam int DEF_ROWS    = 6;
   localparam int DEF_LEVELS  = 16;

   // Pin mapping constants
   localparam logic [2:0] MISSING_PIN  = 3'd5;   // port pin that is not bonded out
   localparam logic [3:0] PIN_MODE_OUT = 4'd2;   // config nibble code for push-pull output
   localparam int         PIN_FIELD_W  = 4;      // config bits per pin

   // Request operation codes
   typedef enum logic [2:0] {
      OP_SET       = 3'd0,
      OP_GET       = 3'd1,
      OP_CLEAR     = 3'd2,
      OP_TICK      = 3'd3,
      OP_POWER_OFF = 3'd4
   } op_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;   // take request beat, launch store read
      logic commit;    // load result register, update store and scan state
   } ctl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic out_free;  // result register empty or being drained this cycle
   } dp_status_type;

endpackage

FILE: src/charlieplex_led_pwm_scanner.sv
// Top level of the charlieplex LED PWM scanner: controller, datapath and store.
// Response: the request is captured in IDLE, then EXEC commits the response beat into
//   the result register and raises rsp_valid, waiting while an older beat is still held.
// Requests: a new beat is taken only once the previous one has committed, because the
//   brightness store read is registered (read at capture, result and write at commit).
// Reset (synchronous, active high): store reads as all zero, scan pixel and PWM slot
//   return to zero, no response pending; usable in the first cycle after reset.
module charlieplex_led_pwm_scanner #(
   parameter int COLUMNS = clpwm_pkg::DEF_COLUMNS,
   parameter int ROWS    = clpwm_pkg::DEF_ROWS,
   parameter int LEVELS  = clpwm_pkg::DEF_LEVELS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [7:0]  req_level,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_read_level,
   output logic [31:0] rsp_pin_config,
   output logic [7:0]  rsp_pin_output,
   output logic        rsp_drive_update,
   output logic        rsp_rejected
);
   import clpwm_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Controller: IDLE takes a beat and launches the store read; EXEC waits for the
   // response register to free up, then commits.
   clpwm_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: store with written flags (clear-all wipes them all at one commit), row and
   // column scan counters, PWM slot counter, pin word mapping and response register.
   clpwm_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .LEVELS  (LEVELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_level   (rsp_read_level),
      .rsp_pin_config   (rsp_pin_config),
      .rsp_pin_output   (rsp_pin_output),
      .rsp_drive_update (rsp_drive_update),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

FILE: src/clpwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clpwm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 36
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/clpwm_ctl.sv
// Control state machine: sequences request capture and result commit.
module clpwm_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  clpwm_pkg::dp_status_type status,
   output clpwm_pkg::ctl_cmd_type   cmd
);
   import clpwm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/clpwm_dp.sv
// Datapath: brightness store, scan counters, pin mapping and result register.
module clpwm_dp #(
   parameter int COLUMNS = clpwm_pkg::DEF_COLUMNS,
   parameter int ROWS    = clpwm_pkg::DEF_ROWS,
   parameter int LEVELS  = clpwm_pkg::DEF_LEVELS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  clpwm_pkg::ctl_cmd_type   cmd,
   output clpwm_pkg::dp_status_type status,
   input  logic [2:0]              req_operation,
   input  logic [7:0]              req_pos_x,
   input  logic [7:0]              req_pos_y,
   input  logic [7:0]              req_level,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_read_level,
   output logic [31:0]             rsp_pin_config,
   output logic [7:0]              rsp_pin_output,
   output logic                    rsp_drive_update,
   output logic                    rsp_rejected
);
   import clpwm_pkg::*;

   localparam int PIX    = COLUMNS * ROWS;
   localparam int ADDR_W = (PIX > 1) ? $clog2(PIX) : 1;
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int SLOT_W = $clog2(LEVELS + 1);

   // captured request
   logic [2:0]        op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              pos_ok_ff;
   logic              level_ok_ff;
   logic [LVL_W-1:0]  level_ff;

   // scan state
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // store written flags: an unwritten entry reads as zero
   logic [PIX-1:0]    written_ff, written_in;

   // result register
   logic              rsp_valid_ff;
   logic [3:0]        read_level_ff, read_level_in;
   logic [31:0]       pin_config_ff, pin_config_in;
   logic [7:0]        pin_output_ff, pin_output_in;
   logic              drive_update_ff, drive_update_in;
   logic              rejected_ff, rejected_in;

   // request address decode
   logic              req_pos_ok;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [LVL_W-1:0]  rd_data;
   logic [LVL_W-1:0]  pix_level;

   // pin mapping
   logic [2:0]        r3, c3, row_pin, col_pin, col_tmp;
   logic              corner;
   logic [31:0]       on_config;
   logic [7:0]        on_output;

   assign req_pos_ok = (req_pos_x < 8'(COLUMNS)) && (req_pos_y < 8'(ROWS));
   assign req_addr   = req_pos_ok
                       ? ADDR_W'(ADDR_W'(req_pos_y[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                                 + ADDR_W'(req_pos_x[COL_W-1:0]))
                       : '0;
   assign rd_addr    = (req_operation == OP_TICK) ? scan_addr_ff : req_addr;
   assign wr_en      = cmd.commit && (op_ff == OP_SET) && pos_ok_ff && level_ok_ff;

   clpwm_ram #(
      .WIDTH (LVL_W),
      .DEPTH (PIX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (level_ff),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read data pairs with addr_ff for get, scan_addr_ff for tick; neither moves
   // between capture and commit.
   always_comb begin
      if (op_ff == OP_TICK) begin
         pix_level = written_ff[scan_addr_ff] ? rd_data : '0;
      end else begin
         pix_level = written_ff[addr_ff] ? rd_data : '0;
      end
   end

   // row pin skips the missing pin; column pin skips the row pin, then the missing pin
   always_comb begin
      r3      = 3'(scan_row_ff);
      c3      = 3'(scan_col_ff);
      corner  = ((r3 == 3'd0) || (r3 == MISSING_PIN)) && ((c3 == 3'd0) || (c3 == MISSING_PIN));
      row_pin = r3 + 3'((r3 >= MISSING_PIN) ? 1 : 0);
      col_tmp = c3 + 3'((c3 >= row_pin) ? 1 : 0);
      col_pin = col_tmp + 3'((col_tmp >= MISSING_PIN) ? 1 : 0);
      if (corner) begin
         on_config = '0;
         on_output = '0;
      end else begin
         on_config = (32'(PIN_MODE_OUT) << (PIN_FIELD_W * row_pin))
                   | (32'(PIN_MODE_OUT) << (PIN_FIELD_W * col_pin));
         on_output = 8'd1 << col_pin;
      end
   end

   // commit-time result and state updates
   always_comb begin
      read_level_in   = '0;
      pin_config_in   = '0;
      pin_output_in   = '0;
      drive_update_in = 1'b0;
      rejected_in     = 1'b0;
      written_in      = written_ff;
      scan_row_in     = scan_row_ff;
      scan_col_in     = scan_col_ff;
      scan_addr_in    = scan_addr_ff;
      slot_in         = slot_ff;
      case (op_ff)
         OP_SET: begin
            rejected_in = !(pos_ok_ff && level_ok_ff);
            if (pos_ok_ff && level_ok_ff) begin
               written_in[addr_ff] = 1'b1;
            end
         end
         OP_GET: begin
            if (pos_ok_ff) begin
               read_level_in = 4'(pix_level);
            end
         end
         OP_CLEAR: begin
            written_in = '0;
         end
         OP_TICK: begin
            pin_config_in   = on_config;
            pin_output_in   = (slot_ff < SLOT_W'(pix_level)) ? on_output : '0;
            drive_update_in = 1'b1;
            if (slot_ff == SLOT_W'(LEVELS)) begin
               slot_in = '0;
               if (scan_col_ff == COL_W'(COLUMNS - 1)) begin
                  scan_col_in = '0;
                  if (scan_row_ff == ROW_W'(ROWS - 1)) begin
                     scan_row_in  = '0;
                     scan_addr_in = '0;
                  end else begin
                     scan_row_in  = scan_row_ff + 1'b1;
                     scan_addr_in = scan_addr_ff + 1'b1;
                  end
               end else begin
                  scan_col_in  = scan_col_ff + 1'b1;
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         OP_POWER_OFF: begin
            drive_update_in = 1'b1;
         end
         default: begin
            drive_update_in = 1'b0;
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         addr_ff     <= req_addr;
         pos_ok_ff   <= req_pos_ok;
         level_ok_ff <= (req_level < 8'(LEVELS));
         level_ff    <= req_level[LVL_W-1:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         scan_addr_ff <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            written_ff   <= written_in;
            scan_row_ff  <= scan_row_in;
            scan_col_ff  <= scan_col_in;
            scan_addr_ff <= scan_addr_in;
            slot_ff      <= slot_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         read_level_ff   <= read_level_in;
         pin_config_ff   <= pin_config_in;
         pin_output_ff   <= pin_output_in;
         drive_update_ff <= drive_update_in;
         rejected_ff     <= rejected_in;
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_level   = read_level_ff;
   assign rsp_pin_config   = pin_config_ff;
   assign rsp_pin_output   = pin_output_ff;
   assign rsp_drive_update = drive_update_ff;
   assign rsp_rejected     = rejected_ff;

endmodule

FILE: sim/testbench.sv
// Self-checking bench for the charlieplex LED PWM scanner: directed, sweep and random beats.
module testbench;
   import clpwm_pkg::*;

   // Geometry of the matrix under test (the DUT runs with its defaults)
   localparam int NUM_COLS    = DEF_COLUMNS;
   localparam int NUM_ROWS    = DEF_ROWS;
   localparam int NUM_LEVELS  = DEF_LEVELS;
   localparam int NUM_PIXELS  = NUM_COLS * NUM_ROWS;

   // Operation codes 5..7 are not decoded; the block must answer them with an all-zero beat
   localparam int OP_SPARE_FIRST = 5;
   localparam int OP_SPARE_LAST  = 7;

   // Quiet cycles (nothing accepted on either channel) before the run is declared hung.
   // Worst honest quiet stretch is set by the long receiver hold below.
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT      = 2000;

   // One response beat, field by field
   typedef struct packed {
      logic [3:0]  read_level;
      logic [31:0] pin_config;
      logic [7:0]  pin_output;
      logic        drive_update;
      logic        rejected;
   } scan_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [7:0]  req_pos_x = '0;
   logic [7:0]  req_pos_y = '0;
   logic [7:0]  req_level = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [3:0]  rsp_read_level;
   logic [31:0] rsp_pin_config;
   logic [7:0]  rsp_pin_output;
   logic        rsp_drive_update;
   logic        rsp_rejected;

   // Shadow copy of the block's state, advanced once per accepted request beat
   logic [3:0]  shadow_levels [NUM_PIXELS];
   int          shadow_pixel;
   int          shadow_slot;

   // Responses predicted but not yet seen, oldest first
   scan_word_type due_words [$];

   // Stimulus controls shared between the sender, the receiver and the test tasks
   bit          gaps_on = 1'b1;     // random idle bursts on both channels
   int          hold_request = 0;   // receiver holds rsp_ready low this many cycles

   int          mismatch_count = 0;
   int          beats_sent = 0;
   int          ticks_sent = 0;
   int          sets_rejected = 0;
   int          words_checked = 0;
   int          quiet_cycles = 0;

   charlieplex_led_pwm_scanner DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_level   (rsp_read_level),
      .rsp_pin_config   (rsp_pin_config),
      .rsp_pin_output   (rsp_pin_output),
      .rsp_drive_update (rsp_drive_update),
      .rsp_rejected     (rsp_rejected)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Prediction: apply one accepted beat to the shadow state and queue the response.
   // ---------------------------------------------------------------------------------
   task automatic step_scanner(input logic [2:0] op, input logic [7:0] x,
                               input logic [7:0] y, input logic [7:0] lvl);
      scan_word_type word;
      int          pix;
      int          row;
      int          col;
      int          row_pin;
      int          col_pin;
      logic [31:0] mode_word;
      logic [31:0] cfg;
      logic [7:0]  lit;
      word = '0;
      mode_word = 32'(PIN_MODE_OUT);
      case (op)
         OP_SET: begin
            if (x >= NUM_COLS || y >= NUM_ROWS || lvl >= NUM_LEVELS) begin
               word.rejected = 1'b1;
               sets_rejected++;
            end else begin
               shadow_levels[int'(y) * NUM_COLS + int'(x)] = lvl[3:0];
            end
         end
         OP_GET: begin
            // out-of-range reads answer zero
            if (x < NUM_COLS && y < NUM_ROWS)
               word.read_level = shadow_levels[int'(y) * NUM_COLS + int'(x)];
         end
         OP_CLEAR: begin
            foreach (shadow_levels[i]) shadow_levels[i] = '0;
         end
         OP_TICK: begin
            pix = (shadow_pixel >= NUM_PIXELS) ? 0 : shadow_pixel;
            row = pix / NUM_COLS;
            col = pix % NUM_COLS;
            cfg = '0;
            lit = '0;
            // corner LEDs are not populated: both pin words stay zero
            if (!((row == 0 || row == MISSING_PIN) && (col == 0 || col == MISSING_PIN))) begin
               row_pin = (row >= MISSING_PIN) ? row + 1 : row;
               col_pin = (col >= row_pin) ? col + 1 : col;
               if (col_pin >= MISSING_PIN) col_pin++;
               cfg = (mode_word << (PIN_FIELD_W * row_pin)) |
                     (mode_word << (PIN_FIELD_W * col_pin));
               lit = 8'd1 << col_pin;
            end
            word.pin_config   = cfg;
            word.pin_output   = (shadow_slot < shadow_levels[pix]) ? lit : 8'd0;
            word.drive_update = 1'b1;
            // each pixel is held for LEVELS+1 slots, then the scan moves on and wraps
            shadow_slot++;
            if (shadow_slot > NUM_LEVELS) begin
               shadow_slot = 0;
               pix++;
               if (pix >= NUM_PIXELS) pix = 0;
            end
            shadow_pixel = pix;
            ticks_sent++;
         end
         OP_POWER_OFF: word.drive_update = 1'b1;
         default: ;
      endcase
      due_words.push_back(word);
   endtask

   // ---------------------------------------------------------------------------------
   // Sender: one request beat. Valid is never dropped between back-to-back beats;
   // it only goes low for an idle burst, so each step sees one assignment at most.
   // ---------------------------------------------------------------------------------
   task automatic send_beat(input logic [2:0] op, input logic [7:0] x,
                            input logic [7:0] y, input logic [7:0] lvl);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_operation <= op;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_level     <= lvl;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge
      step_scanner(op, x, y, lvl);
      beats_sent++;
   endtask

   // Sender goes quiet until every predicted response has been drained
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
   endtask

   // Random beat: mostly well-formed, with some out-of-range coordinates and levels
   task automatic send_random_beat();
      int         pick;
      logic [2:0] op;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] lvl;
      pick = $urandom_range(0, 99);
      if (pick < 35)      op = OP_TICK;
      else if (pick < 62) op = OP_SET;
      else if (pick < 84) op = OP_GET;
      else if (pick < 89) op = OP_CLEAR;
      else if (pick < 95) op = OP_POWER_OFF;
      else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      x   = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, NUM_COLS - 1))
                                        : 8'($urandom_range(0, 255));
      y   = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, NUM_ROWS - 1))
                                        : 8'($urandom_range(0, 255));
      lvl = ($urandom_range(0, 19) < 17) ? 8'($urandom_range(0, NUM_LEVELS - 1))
                                          : 8'($urandom_range(0, 255));
      send_beat(op, x, y, lvl);
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver: random stall bursts while gaps are on, plus one long hold on request.
   // ---------------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            rsp_ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Checker: every accepted response beat against the oldest prediction
   always @(posedge clock) begin : check_words
      scan_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            $error("response beat with nothing outstanding");
            mismatch_count++;
         end else begin
            want = due_words.pop_front();
            words_checked++;
            if (rsp_read_level !== want.read_level) begin
               $error("read_level expected %0d got %0d", want.read_level, rsp_read_level);
               mismatch_count++;
            end
            if (rsp_pin_config !== want.pin_config) begin
               $error("pin_config expected %h got %h", want.pin_config, rsp_pin_config);
               mismatch_count++;
            end
            if (rsp_pin_output !== want.pin_output) begin
               $error("pin_output expected %h got %h", want.pin_output, rsp_pin_output);
               mismatch_count++;
            end
            if (rsp_drive_update !== want.drive_update) begin
               $error("drive_update expected %b got %b", want.drive_update, rsp_drive_update);
               mismatch_count++;
            end
            if (rsp_rejected !== want.rejected) begin
               $error("rejected expected %b got %b", want.rejected, rsp_rejected);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no beat moving on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Extremes of every field, each operation, rejects, out-of-range reads, spare codes
   task automatic test_directed();
      send_beat(OP_GET, 8'd0, 8'd0, 8'd0);                       // fresh store reads zero
      send_beat(OP_SET, 8'd0, 8'd0, 8'(NUM_LEVELS - 1));          // top level, first pixel
      send_beat(OP_SET, 8'(NUM_COLS - 1), 8'(NUM_ROWS - 1), 8'd0);
      send_beat(OP_SET, 8'(NUM_COLS - 1), 8'd0, 8'd9);
      send_beat(OP_SET, 8'd0, 8'(NUM_ROWS - 1), 8'd1);
      send_beat(OP_SET, 8'd2, 8'd3, 8'(NUM_LEVELS));              // level just past the top
      send_beat(OP_SET, 8'd1, 8'd1, 8'hff);
      send_beat(OP_SET, 8'(NUM_COLS), 8'd0, 8'd1);                // column past the edge
      send_beat(OP_SET, 8'd0, 8'(NUM_ROWS), 8'd1);                // row past the edge
      send_beat(OP_SET, 8'hff, 8'hff, 8'd0);
      send_beat(OP_GET, 8'd0, 8'd0, 8'd0);
      send_beat(OP_GET, 8'(NUM_COLS - 1), 8'd0, 8'hff);
      send_beat(OP_GET, 8'(NUM_COLS), 8'd2, 8'd0);                // out of range reads 0
      send_beat(OP_GET, 8'd1, 8'hff, 8'd0);
      send_beat(OP_POWER_OFF, 8'hff, 8'hff, 8'hff);
      send_beat(OP_TICK, 8'd0, 8'd0, 8'd0);                       // corner pixel: zero words
      send_beat(OP_TICK, 8'hff, 8'hff, 8'hff);
      for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
         send_beat(3'(code), 8'($urandom), 8'($urandom), 8'($urandom));
      send_beat(OP_CLEAR, 8'd0, 8'd0, 8'd0);
      send_beat(OP_GET, 8'd0, 8'd0, 8'd0);
      send_beat(OP_GET, 8'(NUM_COLS - 1), 8'd0, 8'd0);
      send_beat(OP_SET, 8'd3, 8'd2, 8'd7);
      send_beat(OP_GET, 8'd3, 8'd2, 8'd0);
   endtask

   // Load every pixel, then tick through a full refresh frame and past the wrap
   task automatic test_scan_sweep();
      for (int row = 0; row < NUM_ROWS; row++)
         for (int col = 0; col < NUM_COLS; col++)
            send_beat(OP_SET, 8'(col), 8'(row), 8'($urandom_range(0, NUM_LEVELS - 1)));
      repeat (NUM_PIXELS * (NUM_LEVELS + 1) + 20)
         send_beat(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Receiver holds off for a long stretch while requests keep coming, then the
   // sender pauses until the pipeline is fully drained
   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_request = LONG_HOLD_CYCLES;
      repeat (40) send_random_beat();
      wait_until_drained();
      gaps_on = 1'b1;
   endtask

   // Bulk random traffic; every third block runs without idle bursts
   task automatic test_random_mix();
      for (int blk = 0; blk < 10; blk++) begin
         gaps_on = (blk % 3 != 2);
         repeat (100) send_random_beat();
      end
      gaps_on = 1'b1;
   endtask

   // Closing stretch at full rate, no idling on either side
   task automatic test_full_rate_tail();
      gaps_on = 1'b0;
      repeat (150) send_random_beat();
   endtask

   initial begin
      foreach (shadow_levels[i]) shadow_levels[i] = '0;
      shadow_pixel = 0;
      shadow_slot  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_scan_sweep();
      test_backpressure();
      test_random_mix();
      test_full_rate_tail();

      wait_until_drained();
      // idle on so that a stray extra response would still be caught
      repeat (16) @(posedge clock);

      $display("covered %0d request beats: %0d PWM ticks, %0d range-rejected sets",
               beats_sent, ticks_sent, sets_rejected);
      $display("checked %0d response beats, %0d field mismatches",
               words_checked, mismatch_count);
      if (mismatch_count == 0 && due_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
